@@ src/line_resampler_5_over_2_defines.svh @@
// assertion helpers for the line resampler
`ifndef LINE_RESAMPLER_5_OVER_2_DEFINES_SVH
`define LINE_RESAMPLER_5_OVER_2_DEFINES_SVH
`ifndef SYNTHESIS
`define LRS_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LRS_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define LRS_ASSERT(label, clk, rstn, prop, msg)
`define LRS_ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif
`endif

@@ src/lrs_pkg.sv @@
package lrs_pkg;
  localparam int unsigned SampleW = 16;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned TapIdxW = 5;
  localparam int unsigned PhaseW  = 3;

  localparam logic CmdLoad   = 1'b0;
  localparam logic CmdSample = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic signed [SampleW-1:0] sample_value;
    logic                      last_in_line;
    logic [1:0]                coef_phase;
    logic [TapIdxW-1:0]        coef_tap;
    logic signed [CoefW-1:0]   coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] out_sample;
    logic                      last_of_run;
    logic                      end_of_line;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_coef;
    logic shift_in;
    logic acc_clear;
    logic acc_step;
    logic [TapIdxW-1:0] tap;
    logic finish;
  } dp_cmd_t;

  function automatic logic [1:0] centre_off(input logic [PhaseW-1:0] ph);
    logic [1:0] r;
    begin
      case (ph)
        3'd0, 3'd1: r = 2'd0;
        3'd2, 3'd3: r = 2'd1;
        default:    r = 2'd2;
      endcase
      return r;
    end
  endfunction
endpackage

@@ src/lrs_if.sv @@
interface lrs_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/lrs_datapath.sv @@
module lrs_datapath #(
  parameter int unsigned HalfTaps = 4
) (
  input  logic                  clk_i,
  input  lrs_pkg::in_item_t     item_i,
  input  lrs_pkg::dp_cmd_t      cmd_i,
  input  logic [lrs_pkg::PhaseW-1:0] phase_i,
  input  logic [13:0]           centre_i,
  input  logic [12:0]           newest_i,
  output logic signed [lrs_pkg::SampleW-1:0] result_o
);
  import lrs_pkg::*;
  localparam int unsigned Taps     = 2 * HalfTaps + 1;
  localparam int unsigned WinDepth = 2 * HalfTaps + 3;
  localparam int unsigned CoefDep  = 4 * Taps;
  localparam int unsigned CAW      = $clog2(CoefDep);
  localparam int unsigned WAW      = $clog2(WinDepth);
  localparam int unsigned AccW     = 32 + $clog2(Taps) + 1;

  logic signed [SampleW-1:0] win_q [WinDepth];
  logic signed [CoefW-1:0]   coef_mem [CoefDep];
  logic signed [CoefW-1:0]   coef_rd_q;
  logic signed [SampleW-1:0] smp_q;
  logic signed [SampleW-1:0] centre_smp_q;
  logic signed [AccW-1:0]    acc_q;
  logic                      step_q;
  logic                      prod_v_q;
  logic signed [31:0]        prod_q;
  logic [CAW-1:0]            waddr, raddr;
  logic signed [15:0]        j;
  logic [13:0]               jc, k;
  logic [WAW-1:0]            kidx;
  logic signed [AccW-1:0]    acc_fin, shifted;

  assign waddr = CAW'(32'(item_i.coef_phase) * Taps + 32'(item_i.coef_tap));
  assign raddr = CAW'(32'(phase_i - 3'd1) * Taps + 32'(cmd_i.tap));

  // clamped window position of the current tap
  always_comb begin
    j = $signed({2'b00, centre_i}) - 16'(HalfTaps) + $signed({11'd0, cmd_i.tap});
    if (j < 0) jc = '0;
    else if (j > $signed({3'b000, newest_i})) jc = {1'b0, newest_i};
    else jc = j[13:0];
    k = {1'b0, newest_i} - jc;
    kidx = (k >= 14'(WinDepth - 1)) ? WAW'(WinDepth - 1) : k[WAW-1:0];
  end

  // tap read and window read, then product, then accumulate
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_coef && item_i.coef_tap < TapIdxW'(Taps)) coef_mem[waddr] <= item_i.coef_value;
    coef_rd_q <= coef_mem[raddr];
    smp_q     <= win_q[kidx];
    if (cmd_i.shift_in) begin
      for (int i = WinDepth - 1; i > 0; i--) win_q[i] <= win_q[i-1];
      win_q[0] <= item_i.sample_value;
    end
    if (cmd_i.acc_clear) centre_smp_q <= win_q[kidx];
    step_q   <= cmd_i.acc_step;
    prod_v_q <= step_q;
    prod_q   <= coef_rd_q * smp_q;
    if (cmd_i.acc_clear) acc_q <= '0;
    else if (prod_v_q) acc_q <= acc_q + AccW'(prod_q);
  end

  always_comb begin
    acc_fin = acc_q + AccW'(8192);
    shifted = acc_fin >>> 14;
    if (phase_i == '0) result_o = centre_smp_q;
    else if (shifted > AccW'(32767)) result_o = 16'sh7fff;
    else if (shifted < -AccW'(32768)) result_o = 16'sh8000;
    else result_o = shifted[15:0];
  end
endmodule

@@ src/lrs_ctrl.sv @@
module lrs_ctrl #(
  parameter int unsigned HalfTaps = 4,
  parameter int unsigned MaxLine  = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  lrs_pkg::in_item_t   item_i,
  output logic                in_ready_o,
  output lrs_pkg::dp_cmd_t    cmd_o,
  output logic [lrs_pkg::PhaseW-1:0] phase_o,
  output logic [13:0]         centre_o,
  output logic [12:0]         newest_o,
  input  logic signed [lrs_pkg::SampleW-1:0] result_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lrs_pkg::out_item_t  out_o
);
  import lrs_pkg::*;
  localparam int unsigned Taps = 2 * HalfTaps + 1;

  typedef enum logic [2:0] {StIdle, StCheck, StMac, StDrain, StEmit} state_e;
  state_e state_q;
  logic [12:0] n_q;
  logic [13:0] oc_q;
  logic [12:0] grp_q;
  logic [PhaseW-1:0] ph_q;
  logic last_q;
  logic [TapIdxW-1:0] tap_q;
  logic [2:0] drain_q;
  logic [13:0] centre;
  logic more;
  logic [14:0] lim;
  logic [14:0] oc_next;
  logic [12:0] grp_next;
  logic [PhaseW-1:0] ph_next;
  logic [13:0] centre_next;
  logic more_next;

  // grp_q counts whole groups of five outputs
  assign centre = 14'({grp_q, 1'b0}) + 14'(centre_off(ph_q));
  assign lim = 15'((15'(n_q) * 5) >> 1);
  assign more = last_q ? (15'(oc_q) <= lim) : (15'(centre) + 15'(HalfTaps) <= 15'(n_q));
  assign oc_next = 15'(oc_q) + 15'd1;
  assign ph_next = (ph_q == 3'd4) ? 3'd0 : ph_q + 3'd1;
  assign grp_next = (ph_q == 3'd4) ? grp_q + 13'd1 : grp_q;
  assign centre_next = 14'({grp_next, 1'b0}) + 14'(centre_off(ph_next));
  assign more_next = last_q ? (oc_next <= lim) : (15'(centre_next) + 15'(HalfTaps) <= 15'(n_q));

  assign in_ready_o = (state_q == StIdle);
  assign phase_o = ph_q;
  assign centre_o = centre;
  assign newest_o = n_q;

  always_comb begin
    cmd_o = '0;
    // centre tap while the centre sample is captured
    cmd_o.tap = (state_q == StCheck) ? TapIdxW'(HalfTaps) : tap_q;
    cmd_o.load_coef = in_valid_i && in_ready_o && item_i.cmd == CmdLoad;
    cmd_o.shift_in  = in_valid_i && in_ready_o && item_i.cmd == CmdSample;
    cmd_o.acc_clear = (state_q == StCheck);
    cmd_o.acc_step  = (state_q == StMac) && ph_q != '0;
  end

  // one item through state machine; MAC one tap a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; n_q <= '0; oc_q <= '0; grp_q <= '0; ph_q <= '0; last_q <= 1'b0;
      tap_q <= '0; drain_q <= '0; out_valid_o <= 1'b0; out_o <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i && item_i.cmd == CmdSample) begin
            last_q <= item_i.last_in_line || (n_q >= 13'(MaxLine - 1));
            state_q <= StCheck;
          end
        end
        StCheck: begin
          tap_q <= '0;
          if (more) state_q <= StMac;
          else begin
            if (last_q) begin n_q <= '0; oc_q <= '0; grp_q <= '0; ph_q <= '0; end
            else n_q <= n_q + 13'd1;
            state_q <= StIdle;
          end
        end
        StMac: begin
          if (ph_q == '0 || tap_q == TapIdxW'(Taps - 1)) begin
            drain_q <= '0; state_q <= StDrain;
          end else tap_q <= tap_q + 1'b1;
        end
        StDrain: begin
          drain_q <= drain_q + 3'd1;
          if (drain_q == 3'd2) begin
            out_valid_o <= 1'b1;
            out_o.out_sample <= result_i;
            out_o.last_of_run <= !more_next;
            out_o.end_of_line <= !more_next && last_q;
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            oc_q <= oc_next[13:0];
            grp_q <= grp_next;
            ph_q <= ph_next;
            state_q <= StCheck;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

@@ src/line_resampler_5_over_2.sv @@
// channel | dir | payload
// in_ch   | in  | cmd, sample_value, last_in_line, coef_phase, coef_tap, coef_value
// out_ch  | out | out_sample, last_of_run, end_of_line
// a coefficient load is taken while idle; a sample is taken while idle, then per
// output come a check, a pass of the single multiply-accumulate over all taps
// (centre sample only for phase 0), a pipeline drain and the output handshake
// reset clears window position and counters; the tap table holds nothing
// until loaded; a stalled output holds the machine
module line_resampler_5_over_2 #(
  parameter int unsigned HALF_TAPS = 4,
  parameter int unsigned MAX_LINE  = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  lrs_if.sink   in_ch,
  lrs_if.source out_ch
);
  import lrs_pkg::*;
`include "line_resampler_5_over_2_defines.svh"

  dp_cmd_t cmd;
  logic [PhaseW-1:0] phase;
  logic [13:0] centre;
  logic [12:0] newest;
  logic signed [SampleW-1:0] result;

  // sequencer: per sample checks each pending output and steps taps
  lrs_ctrl #(.HalfTaps(HALF_TAPS), .MaxLine(MAX_LINE)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .item_i(in_ch.data), .in_ready_o(in_ch.ready),
    .cmd_o(cmd), .phase_o(phase), .centre_o(centre), .newest_o(newest),
    .result_i(result),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready), .out_o(out_ch.data)
  );

  // window, tap table, multiplier and accumulator
  lrs_datapath #(.HalfTaps(HALF_TAPS)) u_dp (
    .clk_i, .item_i(in_ch.data), .cmd_i(cmd), .phase_i(phase),
    .centre_i(centre), .newest_i(newest), .result_o(result)
  );

  `LRS_ASSERT(a_no_accept_busy, clk_i, rst_ni, !(in_ch.ready && out_ch.valid), "accept while output pending")
  `LRS_ASSERT_NEXT(a_eol_run, clk_i, rst_ni, out_ch.valid && out_ch.data.end_of_line, out_ch.data.last_of_run || !out_ch.valid || $stable(out_ch.data), "end of line without end of run")
endmodule

@@ tb/line_resampler_5_over_2_test.sv @@
module line_resampler_5_over_2_test;
  import lrs_pkg::*;

  localparam int Taps = 9;
  localparam int WinDepth = 11;
  localparam int MaxLine = 4096;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lrs_if #(.T(in_item_t))  in_ch ();
  lrs_if #(.T(out_item_t)) out_ch ();

  line_resampler_5_over_2 i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic signed [15:0] win_q [WinDepth];
  logic signed [15:0] taps_q [4*Taps];
  int unsigned in_idx, out_idx, out_ph;
  out_item_t resampled_q [$];

  int errors = 0;
  int n_out_seen = 0;
  int n_in_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic logic signed [15:0] fetch_sample(longint j, longint n);
    longint k;
    if (j < 0) j = 0;
    if (j > n) j = n;
    k = n - j;
    if (k >= WinDepth) k = WinDepth - 1;
    return win_q[k];
  endfunction

  function automatic logic signed [15:0] calc_out(int unsigned c, int unsigned ph,
                                                  int unsigned n);
    longint acc;
    longint q;
    acc = 0;
    if (ph == 0) return fetch_sample(c, n);
    for (int t = 0; t < Taps; t++)
      acc += longint'(taps_q[(ph-1)*Taps+t]) *
             longint'(fetch_sample(longint'(c) - 4 + t, n));
    acc += 8192;
    q = acc >>> 14;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic void predict(in_item_t it);
    int unsigned n, c, cnt;
    int unsigned offs [5] = '{0, 0, 1, 1, 2};
    bit last;
    out_item_t r;
    if (it.cmd == CmdLoad) begin
      if (it.coef_tap < Taps) taps_q[it.coef_phase*Taps+it.coef_tap] = it.coef_value;
      return;
    end
    n = in_idx;
    for (int k = WinDepth-1; k > 0; k--) win_q[k] = win_q[k-1];
    win_q[0] = it.sample_value;
    last = it.last_in_line || (n >= MaxLine-1);
    cnt = 0;
    while (cnt < 40) begin
      c = 2*(out_idx/5) + offs[out_ph];
      if (last) begin
        if (out_idx > (5*n)/2) break;
      end else if (c + 4 > n) break;
      r.out_sample = calc_out(c, out_ph, n);
      r.last_of_run = 1'b0;
      r.end_of_line = 1'b0;
      resampled_q.push_back(r);
      cnt++;
      out_idx++;
      out_ph = (out_ph >= 4) ? 0 : out_ph + 1;
    end
    if (cnt > 0) begin
      resampled_q[$].last_of_run = 1'b1;
      if (last) resampled_q[$].end_of_line = 1'b1;
    end
    if (last) begin
      in_idx = 0; out_idx = 0; out_ph = 0;
    end else in_idx = n + 1;
  endfunction

  // one item per handshake, random gap before it; valid stays up back to back
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict(it);
    n_in_sent++;
  endtask

  task automatic send_tap(int ph, int tap, logic signed [15:0] v);
    in_item_t it;
    it = '0;
    it.cmd = CmdLoad;
    it.coef_phase = ph[1:0];
    it.coef_tap = tap[4:0];
    it.coef_value = v;
    it.sample_value = 16'($urandom);
    it.last_in_line = 1'($urandom_range(1));
    send_item(it);
  endtask

  task automatic send_sample(logic signed [15:0] v, bit last);
    in_item_t it;
    it = '0;
    it.coef_phase = 2'($urandom);
    it.coef_tap = 5'($urandom);
    it.coef_value = 16'($urandom);
    it.cmd = CmdSample;
    it.sample_value = v;
    it.last_in_line = last;
    send_item(it);
  endtask

  // full table: mode 0 random, 1 unit centre, 2 max positive, 3 max negative
  task automatic load_table(int mode);
    logic signed [15:0] v;
    for (int p = 0; p < 4; p++)
      for (int t = 0; t < Taps; t++) begin
        case (mode)
          0: v = 16'($urandom_range(4000) - 1200);
          1: v = (t == 4) ? 16'sd16384 : 16'sd0;
          2: v = 16'sh7fff;
          default: v = 16'sh8000;
        endcase
        send_tap(p, t, v);
      end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (resampled_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic test_directed();
    load_table(1);
    send_sample(16'sh1234, 1'b1);          // one-sample line
    for (int i = 0; i < 6; i++) send_sample(16'(i*100), i == 5);
    send_tap(0, 25, 16'sh7fff);            // tap index out of range ignored
    send_tap(3, 31, 16'sh8000);
    load_table(2);
    for (int i = 0; i < 10; i++) send_sample(16'sh7fff, i == 9);
    for (int i = 0; i < 10; i++) send_sample(16'sh8000, i == 9);
    load_table(3);
    for (int i = 0; i < 10; i++) send_sample((i & 1) ? 16'sh7fff : 16'sh8000, i == 9);
    wait_drained();
  endtask

  task automatic test_random(int n_items, bit reload);
    int len;
    if (reload) load_table(0);
    while (n_items > 0) begin
      if ($urandom_range(9) == 0) begin
        send_tap($urandom_range(3), $urandom_range(31), 16'($urandom_range(4000) - 1200));
        n_items--;
      end else begin
        len = ($urandom_range(4) == 0) ? $urandom_range(2, 30) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
          send_sample(16'($urandom), i == len-1);
        n_items -= len;
      end
    end
    wait_drained();
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      n_out_seen++;
      if (resampled_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_ch.data);
        errors++;
      end else begin
        if (out_ch.data !== resampled_q[0])
          $display("%0t: mismatch expected %p actual %p", $time, resampled_q[0],
                   out_ch.data);
        if (out_ch.data !== resampled_q[0]) errors++;
        void'(resampled_q.pop_front());
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < WinDepth; i++) win_q[i] = '0;
    for (int i = 0; i < 4*Taps; i++) taps_q[i] = '0;
    in_idx = 0; out_idx = 0; out_ph = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(45, 1'b1);
    send_idle_pct = 72; recv_stall_pct = 0;  test_random(45, 1'b0);
    send_idle_pct = 0;  recv_stall_pct = 72; test_random(45, 1'b0);
    send_idle_pct = 23; recv_stall_pct = 23; test_random(45, 1'b0);
    $display("covered %0d input items and %0d results: table loads, edge lines,",
             n_in_sent, n_out_seen);
    $display("saturation and random lines under sender and receiver idling");
    if (errors == 0 && resampled_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end
endmodule
